### sv/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SOFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sofl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SOFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sofl assertion failed");

`endif

### sv/sofl_pkg.sv
// Package with types and constants of the sparse offset index floor lookup.
package sofl_pkg;

    localparam int unsigned DEPTH = 1024;
    localparam int unsigned IDX_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;

    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_ORDER = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key;
        logic [31:0] position;
    } req_t;

    typedef struct packed {
        logic [31:0] found_position;
        status_t     status;
    } rsp_t;

endpackage

### sv/sparse_offset_index_floor_lookup_core.sv
// Sparse offset index: ordered append of key/position pairs and floor lookup by key.
//
// A request is taken when start is high and busy is low; every request yields
// exactly one response, shown for one cycle with done high (no backpressure, so
// the response must be captured in that cycle). Append, clear, the unused opcode
// and a lookup on an empty table respond in the cycle after the request, except an
// append to a non-empty, non-full table, which reads the last stored key in S_ACHK
// first and then responds. A lookup runs a binary search with one step per cycle
// in S_STEP, bounded by the registered read of the key memory, then reads the
// floor position in S_DONE and responds. Key and position memories each have one
// read and one write port and are never cleared; clear only resets the entry count.
module sparse_offset_index_floor_lookup_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  sofl_pkg::req_t  req,
    output logic            done,
    output sofl_pkg::rsp_t  rsp
);
    import sofl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACHK,
        S_STEP,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg, req_next;
    cnt_t   count_reg, count_next;
    cnt_t   lo_reg, lo_next;
    cnt_t   hi_reg, hi_next;
    idx_t   mid_reg, mid_next;
    logic   done_reg, done_next;
    rsp_t   rsp_reg, rsp_next;

    logic [31:0] key_mem [DEPTH];
    logic [31:0] pos_mem [DEPTH];
    logic [31:0] key_q;
    logic [31:0] pos_q;

    idx_t        rd_addr;
    logic        wr_en;
    idx_t        wr_addr;
    logic [31:0] wr_key;
    logic [31:0] wr_pos;

    logic        tgt_less;
    cnt_t        mid_inc;
    cnt_t        step_lo;
    cnt_t        step_hi;
    cnt_t        step_mid;
    cnt_t        step_floor;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    assign tgt_less   = (req_reg.key < key_q);
    assign mid_inc    = {1'b0, mid_reg} + cnt_t'(1);
    assign step_lo    = tgt_less ? lo_reg : mid_inc;
    assign step_hi    = tgt_less ? cnt_t'({1'b0, mid_reg}) : hi_reg;
    assign step_mid   = step_lo + ((step_hi - step_lo) >> 1);
    assign step_floor = (step_lo == '0) ? '0 : step_lo - cnt_t'(1);

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        rd_addr    = mid_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[IDX_W-1:0];
        wr_key     = req_reg.key;
        wr_pos     = req_reg.position;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    rsp_next = '{found_position: 32'd0, status: ST_OK};
                    case (req.opcode)
                        OP_APPEND:
                        begin
                            if (count_reg == cnt_t'(DEPTH))
                            begin
                                rsp_next.status = ST_FULL;
                                done_next       = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_key     = req.key;
                                wr_pos     = req.position;
                                count_next = count_reg + cnt_t'(1);
                                done_next  = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = idx_t'(count_reg - cnt_t'(1));
                                state_next = S_ACHK;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ST_EMPTY;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hi_next    = count_reg;
                                rd_addr    = idx_t'(count_reg >> 1);
                                mid_next   = idx_t'(count_reg >> 1);
                                state_next = S_STEP;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            done_next  = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_ACHK:
            begin
                if (tgt_less)
                begin
                    rsp_next.status = ST_ORDER;
                end
                else
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + cnt_t'(1);
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            S_STEP:
            begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi)
                begin
                    rd_addr  = step_mid[IDX_W-1:0];
                    mid_next = step_mid[IDX_W-1:0];
                end
                else
                begin
                    rd_addr    = step_floor[IDX_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                rsp_next.found_position = pos_q;
                done_next               = 1'b1;
                state_next              = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            rsp_reg   <= '{found_position: 32'd0, status: ST_OK};
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
    end

    // key and position memories with one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            pos_mem[wr_addr] <= wr_pos;
        end
        key_q <= key_mem[rd_addr];
        pos_q <= pos_mem[rd_addr];
    end

endmodule

### sv/sofl_checker.sv
// Port-level assertion checker for the sparse offset index core, with its bind.
`include "assert_macros.svh"

module sofl_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input sofl_pkg::req_t req,
    input logic           done,
    input sofl_pkg::rsp_t rsp
);
    import sofl_pkg::*;

    logic accept;
    logic drop_or_empty;

    assign accept        = start && !busy;
    assign drop_or_empty = (rsp.status == ST_EMPTY) || (rsp.status == ST_FULL)
                           || (rsp.status == ST_ORDER);

    `SOFL_ASSERT_IMP(a_done_not_busy, clk, rst_n, done, !busy)
    `SOFL_ASSERT_NXT(a_accept_progress, clk, rst_n, accept, done || busy)
    `SOFL_ASSERT_IMP(a_busy_end_responds, clk, rst_n, $fell(busy), done)
    `SOFL_ASSERT_IMP(a_error_zero_pos, clk, rst_n, done && drop_or_empty,
                     rsp.found_position == 32'd0)
    `SOFL_ASSERT_NXT(a_append_zero_pos, clk, rst_n,
                     accept && (req.opcode == OP_APPEND) && (busy == 1'b0),
                     !done || (rsp.found_position == 32'd0))

endmodule

bind sparse_offset_index_floor_lookup_core sofl_checker u_sofl_checker (.*);
